[src/triac_phase_fire_control_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the triac phase fire control block
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TRIAC_PHASE_FIRE_CONTROL_ASSERT_SVH
`define TRIAC_PHASE_FIRE_CONTROL_ASSERT_SVH

// same-cycle implication
`define TPFC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tpfc assertion failed");

// next-cycle implication
`define TPFC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tpfc assertion failed");

`endif

[src/tpfc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpfc_pkg
// Types and constants shared by the triac phase fire control block.
// ----------------------------------------------------------------------------
package tpfc_pkg;

    localparam int unsigned CAP_W    = 16;
    localparam int unsigned GEAR_W   = 2;
    localparam int unsigned RUN_W    = 8;
    localparam int unsigned OFFSET_W = 6;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned CROSS_W  = 32;

    localparam int unsigned HALF_CYCLE_TICKS_DEF = 60;

    localparam logic KIND_CAPTURE = 1'b0;
    localparam logic KIND_TICK    = 1'b1;

    localparam logic [GEAR_W-1:0] PWR_OFF  = 2'd0;
    localparam logic [GEAR_W-1:0] PWR_HALF = 2'd1;
    localparam logic [GEAR_W-1:0] PWR_FULL = 2'd2;

    localparam logic [CAP_W-1:0]    LONG_CAPTURE   = 16'd20000;
    localparam logic [OFFSET_W-1:0] OFFSET_DEFAULT = 6'd25;
    localparam logic [7:0]          OFFSET_LO      = 8'd10;
    localparam logic [7:0]          OFFSET_HI      = 8'd40;

    // width / 320 = (width >> 6) / 5, and x / 5 = (x * 205) >> 10 for x < 1024
    localparam int unsigned DIV_SHIFT   = 6;
    localparam int unsigned RECIP_SHIFT = 10;
    localparam logic [7:0]  RECIP_5     = 8'd205;

    localparam logic [COUNT_W-1:0] WINDOW_LEN   = 8'd5;
    localparam logic [RUN_W-1:0]   RUN_TIME_MIN = 8'd2;
    localparam logic [CROSS_W-1:0] HALF_CROSSINGS = 32'd3;

    typedef struct packed {
        logic                is_long;
        logic [OFFSET_W-1:0] offset;
    } t_cap_info;

endpackage

[src/tpfc_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpfc_in_if / tpfc_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface tpfc_in_if;
    logic                            valid;
    logic                            ready;
    logic                            kind;
    logic [tpfc_pkg::CAP_W-1:0]      capture_value;
    logic [tpfc_pkg::GEAR_W-1:0]     requested_gear;
    logic [tpfc_pkg::RUN_W-1:0]      run_time;

    modport source (output valid, kind, capture_value, requested_gear, run_time,
                    input ready);
    modport sink   (input valid, kind, capture_value, requested_gear, run_time,
                    output ready);
endinterface

interface tpfc_out_if;
    logic                            valid;
    logic                            ready;
    logic                            heat_on;
    logic [tpfc_pkg::OFFSET_W-1:0]   phase_offset;
    logic [tpfc_pkg::GEAR_W-1:0]     active_gear;

    modport source (output valid, heat_on, phase_offset, active_gear, input ready);
    modport sink   (input valid, heat_on, phase_offset, active_gear, output ready);
endinterface

[src/tpfc_offset.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpfc_offset
// Classifies a capture width and derives the phase offset (width / 320, or the default when outside the range).
// ----------------------------------------------------------------------------
module tpfc_offset (
    input  logic [tpfc_pkg::CAP_W-1:0] i_capture_value,
    output tpfc_pkg::t_cap_info        o_info
);

    localparam int unsigned X_W = tpfc_pkg::CAP_W - tpfc_pkg::DIV_SHIFT;
    localparam int unsigned P_W = X_W + 8;

    logic [X_W-1:0] x;
    logic [P_W-1:0] prod;
    logic [7:0]     quot;
    logic           in_range;

    assign x        = i_capture_value[tpfc_pkg::CAP_W-1:tpfc_pkg::DIV_SHIFT];
    assign prod     = P_W'(x) * P_W'(tpfc_pkg::RECIP_5);
    assign quot     = prod[tpfc_pkg::RECIP_SHIFT +: 8];
    assign in_range = (quot > tpfc_pkg::OFFSET_LO) && (quot < tpfc_pkg::OFFSET_HI);

    assign o_info.is_long = (i_capture_value >= tpfc_pkg::LONG_CAPTURE);
    assign o_info.offset  = in_range ? quot[tpfc_pkg::OFFSET_W-1:0]
                                     : tpfc_pkg::OFFSET_DEFAULT;

endmodule

[src/triac_phase_fire_control.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triac_phase_fire_control
// Heater triac phase-angle firing from mains zero-cross captures and ticks.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle while the output register is free. Each
// accepted item updates the control state (gear, phase offset, crossing
// count, countdown, gate drive) in one pass, and its result appears on the
// output channel in the next cycle, straight from those state registers. A
// new item is accepted whenever the output register is empty or its result
// is transferred in the same cycle, so with a ready sink the block runs at
// one item per cycle.
// ----------------------------------------------------------------------------
module triac_phase_fire_control #(
    parameter int unsigned HALF_CYCLE_TICKS = tpfc_pkg::HALF_CYCLE_TICKS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tpfc_in_if.sink           i_in,
    tpfc_out_if.source        o_out
);

    localparam logic [tpfc_pkg::COUNT_W-1:0] HALF_LOAD =
        tpfc_pkg::COUNT_W'(HALF_CYCLE_TICKS);

    logic [tpfc_pkg::GEAR_W-1:0]   r_gear,    n_gear;
    logic [tpfc_pkg::OFFSET_W-1:0] r_phase,   n_phase;
    logic [tpfc_pkg::CROSS_W-1:0]  r_cross,   n_cross;
    logic [tpfc_pkg::COUNT_W-1:0]  r_count,   n_count;
    logic                          r_drive,   n_drive;
    logic                          r_valid,   n_valid;

    tpfc_pkg::t_cap_info           cap_info;
    logic                          accept;
    logic [tpfc_pkg::CROSS_W-1:0]  cross_inc;
    logic [tpfc_pkg::COUNT_W-1:0]  win_hi;
    logic [tpfc_pkg::COUNT_W-1:0]  win_lo;
    logic                          in_window;

    tpfc_offset u_offset (
        .i_capture_value (i_in.capture_value),
        .o_info          (cap_info)
    );

    assign i_in.ready = !r_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    assign cross_inc = r_cross + 1'b1;
    assign win_hi    = HALF_LOAD - tpfc_pkg::COUNT_W'(r_phase);
    assign win_lo    = win_hi - tpfc_pkg::WINDOW_LEN;
    assign in_window = (r_count >= win_lo) && (r_count <= win_hi);

    always_comb begin
        n_gear  = r_gear;
        n_phase = r_phase;
        n_cross = r_cross;
        n_count = r_count;
        n_drive = r_drive;
        n_valid = r_valid && !o_out.ready;
        if (accept) begin
            n_valid = 1'b1;
            if (i_in.kind == tpfc_pkg::KIND_CAPTURE) begin
                if (!cap_info.is_long) begin
                    n_phase = cap_info.offset;
                end else begin
                    n_cross = cross_inc;
                    if (r_gear == tpfc_pkg::PWR_HALF
                        && cross_inc >= tpfc_pkg::HALF_CROSSINGS) begin
                        n_cross = '0;
                        n_count = HALF_LOAD;
                    end
                    if (r_gear == tpfc_pkg::PWR_FULL && !cross_inc[0]) begin
                        n_count = HALF_LOAD;
                    end
                end
            end else begin
                if (r_count == '0) begin
                    n_gear = i_in.requested_gear;
                end else begin
                    n_count = r_count - 1'b1;
                    if (in_window) begin
                        if (i_in.run_time > tpfc_pkg::RUN_TIME_MIN) begin
                            n_drive = 1'b1;
                        end
                    end else begin
                        n_drive = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gear  <= tpfc_pkg::PWR_OFF;
            r_phase <= tpfc_pkg::OFFSET_DEFAULT;
            r_cross <= '0;
            r_count <= '0;
            r_drive <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_gear  <= n_gear;
            r_phase <= n_phase;
            r_cross <= n_cross;
            r_count <= n_count;
            r_drive <= n_drive;
            r_valid <= n_valid;
        end
    end

    // state only moves on a transfer in, so it doubles as the result register
    assign o_out.valid        = r_valid;
    assign o_out.heat_on      = r_drive;
    assign o_out.phase_offset = r_phase;
    assign o_out.active_gear  = r_gear;

endmodule

[src/tpfc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpfc_checker
// Port-level checks on the triac phase fire control block, bound to the top.
// ----------------------------------------------------------------------------
`include "triac_phase_fire_control_assert.svh"

module tpfc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              i_in_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic                              i_heat_on,
    input logic [tpfc_pkg::OFFSET_W-1:0]     i_phase_offset,
    input logic [tpfc_pkg::GEAR_W-1:0]       i_active_gear
);

    `TPFC_ASSERT_NOW(a_offset_range, i_out_valid, (i_phase_offset >= 6'd11) && (i_phase_offset <= 6'd39))
    `TPFC_ASSERT_NEXT(a_in_gives_out, i_in_valid && i_in_ready, i_out_valid)
    `TPFC_ASSERT_NOW(a_out_has_source, i_out_valid && !$past(i_out_valid), $past(i_in_valid && i_in_ready))
    `TPFC_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_heat_on) && $stable(i_phase_offset) && $stable(i_active_gear))

endmodule

bind triac_phase_fire_control tpfc_checker u_tpfc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_heat_on      (o_out.heat_on),
    .i_phase_offset (o_out.phase_offset),
    .i_active_gear  (o_out.active_gear)
);
